// ===== rtl/core/size_class_buffer_pool_unit_defines.svh =====
// assertion macros for the size class buffer pool unit
// used by the top level; expects clk and rst in scope
`ifndef SIZE_CLASS_BUFFER_POOL_UNIT_DEFINES_SVH
`define SIZE_CLASS_BUFFER_POOL_UNIT_DEFINES_SVH

// condition holds at every edge outside reset
`define SCBP_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("scbp check failed");

// consequence holds in the cycle after the antecedent
`define SCBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scbp check failed");

`endif

// ===== rtl/core/scbp_pkg.sv =====
// shared types and codes of the size class buffer pool unit
// no dependencies; imported by every module of the block but scbp_ram
package scbp_pkg;

  localparam int WORD_W    = 32;
  localparam int BS_W      = 21;
  localparam int BLK_W     = 4;
  localparam int GRANT_W   = 24;
  localparam int STATUS_W  = 3;
  localparam int CLS_MAX_W = 6;
  localparam int BYTES_W   = 25;
  localparam int CFG_IDX_W = 3;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = 1;
  localparam int Q_CNT_W   = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_REUSED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FRESH    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CACHED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLK_BYTES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BLOCKS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLOCKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_LIMIT = 3'd4;

  // request kinds
  localparam logic OP_GET  = 1'b0;
  localparam logic OP_FREE = 1'b1;

  typedef struct packed {
    logic [BS_W-1:0]   blk_bytes;
    logic [BLK_W-1:0]  min_blocks;
    logic [BLK_W-1:0]  max_blocks;
    logic [WORD_W-1:0] alloc_limit;
    logic [WORD_W-1:0] cache_limit;
  } cfg_t;

  // classified request passed from front to back
  typedef struct packed {
    logic                 op;
    logic                 ok;
    logic [CLS_MAX_W-1:0] cls;
    logic [BYTES_W-1:0]   bytes;
    logic [WORD_W-1:0]    baddr;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/core/scbp_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module scbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/scbp_front.sv =====
// front end: accepts requests, rounds the size to blocks and classifies
// depends on scbp_pkg; feeds scbp_queue
module scbp_front import scbp_pkg::*; #(
  parameter int NUM_CLASSES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic [WORD_W-1:0] in_size,
  input  logic [WORD_W-1:0] in_baddr,
  input  q_status_t         q_st,
  output logic              q_push,
  output req_t              q_entry
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_CLS  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]        state;
  logic [4:0]        step;
  logic [WORD_W-1:0] dvd;
  logic [WORD_W-1:0] quot;
  logic [BS_W-1:0]   rem;
  logic              op;
  logic [WORD_W-1:0] baddr;
  req_t              entry;

  logic [BS_W:0]     rem_sh;
  logic              ge;
  logic [BS_W:0]     rem_sub;
  logic [WORD_W:0]   blocks;
  logic [BLK_W-1:0]  cls_diff;
  logic              cls_ok;
  logic [BYTES_W-1:0] bytes;

  assign in_ready = (state == F_IDLE);
  assign q_push   = (state == F_PUSH) && !q_st.full;
  assign q_entry  = entry;

  // one restoring division step
  always_comb begin
    rem_sh  = {rem, dvd[WORD_W-1]};
    ge      = rem_sh >= {1'b0, cfg.blk_bytes};
    rem_sub = rem_sh - {1'b0, cfg.blk_bytes};
  end

  // ceiling, class range check and byte count
  always_comb begin
    blocks   = {1'b0, quot} + (WORD_W+1)'(rem != '0);
    cls_diff = blocks[BLK_W-1:0] - cfg.min_blocks;
    cls_ok   = (cfg.blk_bytes != '0) &&
               (blocks >= (WORD_W+1)'(cfg.min_blocks)) &&
               (blocks <= (WORD_W+1)'(cfg.max_blocks)) &&
               (32'(cls_diff) < NUM_CLASSES);
    bytes    = BYTES_W'(blocks[BLK_W-1:0]) * BYTES_W'(cfg.blk_bytes);
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            state <= F_DIV;
            step  <= '0;
          end
        end
        F_DIV: begin
          step <= step + 5'd1;
          if (step == 5'd31) begin
            state <= F_CLS;
          end
        end
        F_CLS: begin
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_st.full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid) begin
      dvd   <= in_size;
      quot  <= '0;
      rem   <= '0;
      op    <= in_op;
      baddr <= in_baddr;
    end else if (state == F_DIV) begin
      dvd  <= {dvd[WORD_W-2:0], 1'b0};
      quot <= {quot[WORD_W-2:0], ge};
      rem  <= ge ? rem_sub[BS_W-1:0] : rem_sh[BS_W-1:0];
    end
    if (state == F_CLS) begin
      entry.op    <= op;
      entry.ok    <= cls_ok;
      entry.cls   <= CLS_MAX_W'(cls_diff);
      entry.bytes <= bytes;
      entry.baddr <= baddr;
    end
  end

endmodule

// ===== rtl/core/scbp_queue.sv =====
// two entry queue of classified requests between front and back
// depends on scbp_pkg
module scbp_queue import scbp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  req_t      din,
  input  logic      pop,
  output req_t      dout,
  output q_status_t st
);

  req_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign dout     = mem[rd_ptr];
  assign st.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign st.empty = (count == '0);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ===== rtl/core/scbp_back.sv =====
// back end: class stacks, in-use byte count and the result register
// depends on scbp_pkg and scbp_ram; drains scbp_queue
module scbp_back import scbp_pkg::*; #(
  parameter int NUM_CLASSES = 8,
  parameter int STACK_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  q_status_t           q_st,
  input  req_t                q_dout,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [WORD_W-1:0]   out_addr,
  output logic [GRANT_W-1:0]  out_granted,
  output logic [WORD_W-1:0]   out_in_use
);

  localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int SLOTS  = NUM_CLASSES * STACK_DEPTH;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_CNT  = 2'd1;
  localparam logic [1:0] B_POP  = 2'd2;

  logic [1:0]             state;
  req_t                   cur;
  logic [NUM_CLASSES-1:0] cnt_valid;
  logic [WORD_W-1:0]      in_use;

  logic [CLS_W-1:0]   cls;
  logic [CNT_W-1:0]   cnt_rd;
  logic [CNT_W-1:0]   count;
  logic               cnt_we;
  logic [CNT_W-1:0]   cnt_wdata;
  logic               stk_we;
  logic [CNT_W-1:0]   stk_idx;
  logic [SLOT_W-1:0]  slot;
  logic [WORD_W-1:0]  stk_rd;
  logic [GRANT_W-1:0] grant;
  logic [WORD_W:0]    sum;
  logic               start;
  logic               release_now;
  logic [WORD_W-1:0]  in_use_next;
  logic [STATUS_W-1:0] status_next;
  logic [GRANT_W-1:0] granted_next;
  logic [1:0]         state_next;

  assign cls   = cur.cls[CLS_W-1:0];
  assign count = cnt_valid[cls] ? cnt_rd : '0;
  assign start = (state == B_IDLE) && !q_st.empty && !out_valid;
  assign q_pop = start;

  // per class stack fill counts
  scbp_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_CLASSES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cls),
    .wdata (cnt_wdata),
    .raddr (q_dout.cls[CLS_W-1:0]),
    .rdata (cnt_rd)
  );

  // cached addresses, one row of STACK_DEPTH per class
  scbp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (slot),
    .wdata (cur.baddr),
    .raddr (slot),
    .rdata (stk_rd)
  );

  // decision on the count read back
  always_comb begin
    grant        = (cur.bytes > BYTES_W'(24'hFFFFFF)) ? 24'hFFFFFF : cur.bytes[GRANT_W-1:0];
    sum          = {1'b0, in_use} + (WORD_W+1)'(cur.bytes);
    release_now  = (in_use >= cfg.cache_limit) || (32'(count) >= STACK_DEPTH);
    stk_idx      = (cur.op == OP_GET) ? count - CNT_W'(1) : count;
    slot         = SLOT_W'(cls) * SLOT_W'(STACK_DEPTH) + SLOT_W'(stk_idx);
    cnt_we       = 1'b0;
    cnt_wdata    = count;
    stk_we       = 1'b0;
    in_use_next  = in_use;
    status_next  = ST_FULL;
    granted_next = '0;
    state_next   = B_IDLE;
    if (cur.op == OP_GET) begin
      if (count != '0) begin
        cnt_we       = (state == B_CNT);
        cnt_wdata    = count - CNT_W'(1);
        status_next  = ST_REUSED;
        granted_next = grant;
        state_next   = B_POP;
      end else if (in_use < cfg.alloc_limit) begin
        in_use_next  = sum[WORD_W] ? '1 : sum[WORD_W-1:0];
        status_next  = ST_FRESH;
        granted_next = grant;
      end
    end else begin
      if (release_now) begin
        in_use_next = (in_use < WORD_W'(cur.bytes)) ? '0 : in_use - WORD_W'(cur.bytes);
        status_next = ST_RELEASED;
      end else begin
        stk_we      = (state == B_CNT);
        cnt_we      = (state == B_CNT);
        cnt_wdata   = count + CNT_W'(1);
        status_next = ST_CACHED;
      end
    end
  end

  // sequencer and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      cnt_valid <= '0;
      in_use    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cnt_we) begin
        cnt_valid[cls] <= 1'b1;
      end
      unique case (state)
        B_IDLE: begin
          if (start) begin
            if (q_dout.ok) begin
              state <= B_CNT;
            end else begin
              out_valid <= 1'b1;
            end
          end
        end
        B_CNT: begin
          in_use <= in_use_next;
          state  <= state_next;
          if (state_next == B_IDLE) begin
            out_valid <= 1'b1;
          end
        end
        B_POP: begin
          out_valid <= 1'b1;
          state     <= B_IDLE;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // current item and result payload
  always_ff @(posedge clk) begin
    if (start) begin
      cur         <= q_dout;
      out_status  <= ST_INVALID;
      out_addr    <= '0;
      out_granted <= '0;
      out_in_use  <= in_use;
    end else if (state == B_CNT) begin
      out_status  <= status_next;
      out_granted <= granted_next;
      out_in_use  <= in_use_next;
    end else if (state == B_POP) begin
      out_addr <= stk_rd;
    end
  end

endmodule

// ===== rtl/core/size_class_buffer_pool_unit.sv =====
// top level of the size class buffer pool unit: config registers and wiring
// depends on scbp_pkg, scbp_front, scbp_queue, scbp_back and the defines header
//
// channel   dir  handshake               payload
// s_axis    in   tvalid / tready         tuser op, tdata size_bytes, buffer_addr
// m_axis    out  tvalid / tready         tuser status, tdata addr, granted, in_use
// cfg       in   cfg_we                  cfg_index, cfg_data
//
// a request passes the front end states in order: accept, the bit-serial size
// divider, classify and enter the queue; a new request is taken only once the
// last has entered the queue. the back end overlaps the next division. reset
// clears control state and stack counts at once, no clearing pass. a stalled
// result holds the back end; the front keeps going until the two entry queue
// fills.
`include "size_class_buffer_pool_unit_defines.svh"

module size_class_buffer_pool_unit import scbp_pkg::*; #(
  parameter int NUM_CLASSES = 8,
  parameter int STACK_DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,   // size_bytes, buffer_addr
  input  logic [0:0]           s_axis_tuser,   // op
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [87:0]          m_axis_tdata,   // addr, granted_bytes, in_use_bytes
  output logic [STATUS_W-1:0]  m_axis_tuser,   // status
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  cfg_t               cfg;
  q_status_t          q_st;
  logic               q_push;
  logic               q_pop;
  req_t               q_din;
  req_t               q_dout;
  logic [WORD_W-1:0]  res_addr;
  logic [GRANT_W-1:0] res_granted;
  logic [WORD_W-1:0]  res_in_use;
  logic               res_invalid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blk_bytes   <= BS_W'(16384);
      cfg.min_blocks  <= BLK_W'(1);
      cfg.max_blocks  <= BLK_W'(5);
      cfg.alloc_limit <= 32'd4194304;
      cfg.cache_limit <= 32'd2097152;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLK_BYTES:   cfg.blk_bytes   <= cfg_data[BS_W-1:0];
        CFG_MIN_BLOCKS:  cfg.min_blocks  <= cfg_data[BLK_W-1:0];
        CFG_MAX_BLOCKS:  cfg.max_blocks  <= cfg_data[BLK_W-1:0];
        CFG_ALLOC_LIMIT: cfg.alloc_limit <= cfg_data;
        CFG_CACHE_LIMIT: cfg.cache_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // request classification
  scbp_front #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (s_axis_tuser[0]),
    .in_size  (s_axis_tdata[31:0]),
    .in_baddr (s_axis_tdata[63:32]),
    .q_st     (q_st),
    .q_push   (q_push),
    .q_entry  (q_din)
  );

  // decoupling queue
  scbp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_din),
    .pop  (q_pop),
    .dout (q_dout),
    .st   (q_st)
  );

  // stack and byte count update
  scbp_back #(
    .NUM_CLASSES (NUM_CLASSES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_st        (q_st),
    .q_dout      (q_dout),
    .q_pop       (q_pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_status  (m_axis_tuser),
    .out_addr    (res_addr),
    .out_granted (res_granted),
    .out_in_use  (res_in_use)
  );

  assign m_axis_tdata = {res_in_use, res_granted, res_addr};

  // pending result that reports an invalid size
  assign res_invalid = m_axis_tvalid && (m_axis_tuser == ST_INVALID);

  // checks
  `SCBP_ASSERT(a_no_push_when_full, !(q_push && q_st.full))
  `SCBP_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `SCBP_ASSERT(a_invalid_is_clean, !res_invalid || (m_axis_tdata[55:0] == 56'd0))

endmodule

// ===== bench/tb_size_class_buffer_pool_unit.sv =====
// testbench for the size class buffer pool unit: directed and random request streams
// checked field by field against an in-bench model of the pool policy
// depends on scbp_pkg and the size_class_buffer_pool_unit rtl
`timescale 1ns / 1ps

module tb_size_class_buffer_pool_unit;
  import scbp_pkg::*;

  localparam int NUM_CLASSES = 8;
  localparam int STACK_DEPTH = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_PRINTED = 64;
  localparam int BACKLOG_HOLD = 400;
  // index past the register list, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   addr;
    logic [GRANT_W-1:0]  granted;
    logic [WORD_W-1:0]   in_use;
  } pool_result_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata;   // size_bytes, buffer_addr
  logic [0:0]           s_axis_tuser;   // op
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [87:0]          m_axis_tdata;   // addr, granted_bytes, in_use_bytes
  logic [STATUS_W-1:0]  m_axis_tuser;   // status
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  // model of the pool: registers, per class lifo stacks, in-use byte count
  cfg_t               pool_cfg;
  logic [WORD_W-1:0]  cached_addr [NUM_CLASSES][STACK_DEPTH];
  int                 class_fill [NUM_CLASSES];
  logic [WORD_W-1:0]  in_use_total;

  pool_result_t pool_expected [$];
  int  err_count = 0;
  int  cycle_count = 0;
  bit  src_idle_on = 1'b1;
  bit  sink_idle_on = 1'b1;
  int  sink_hold_cycles = 0;

  size_class_buffer_pool_unit #(
    .NUM_CLASSES(NUM_CLASSES),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    if (err_count < MAX_PRINTED)
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, field, got, want);
    err_count++;
  endtask

  function automatic void reset_pool_model();
    pool_cfg.blk_bytes   = 21'd16384;
    pool_cfg.min_blocks  = 4'd1;
    pool_cfg.max_blocks  = 4'd5;
    pool_cfg.alloc_limit = 32'd4194304;
    pool_cfg.cache_limit = 32'd2097152;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      class_fill[c] = 0;
      for (int d = 0; d < STACK_DEPTH; d++) cached_addr[c][d] = '0;
    end
    in_use_total = '0;
  endfunction

  // round the size to blocks, pick the class, then pop/grant/refuse or push/release
  function automatic pool_result_t predict_pool_outcome(input logic op,
      input logic [WORD_W-1:0] size, input logic [WORD_W-1:0] baddr);
    pool_result_t res;
    logic [63:0]  blocks;
    logic [63:0]  bytes;
    logic [63:0]  sum;
    int           cls;
    logic         sized_ok;
    res = '0;
    sized_ok = 1'b0;
    bytes = '0;
    cls = 0;
    if (pool_cfg.blk_bytes != '0) begin
      blocks = (64'(size) + 64'(pool_cfg.blk_bytes) - 64'd1) / 64'(pool_cfg.blk_bytes);
      if (blocks >= 64'(pool_cfg.min_blocks) && blocks <= 64'(pool_cfg.max_blocks) &&
          blocks - 64'(pool_cfg.min_blocks) < 64'(NUM_CLASSES)) begin
        sized_ok = 1'b1;
        cls = int'(blocks - 64'(pool_cfg.min_blocks));
        bytes = blocks * 64'(pool_cfg.blk_bytes);
      end
    end
    if (!sized_ok) begin
      res.status = ST_INVALID;
    end else if (op == OP_GET) begin
      res.granted = (bytes > 64'hFF_FFFF) ? '1 : bytes[GRANT_W-1:0];
      if (class_fill[cls] > 0) begin
        class_fill[cls]--;
        res.addr = cached_addr[cls][class_fill[cls]];
        res.status = ST_REUSED;
      end else if (in_use_total < pool_cfg.alloc_limit) begin
        sum = 64'(in_use_total) + bytes;
        in_use_total = (sum > 64'hFFFF_FFFF) ? '1 : sum[WORD_W-1:0];
        res.status = ST_FRESH;
      end else begin
        res.granted = '0;
        res.status = ST_FULL;
      end
    end else begin
      if (in_use_total >= pool_cfg.cache_limit || class_fill[cls] >= STACK_DEPTH) begin
        in_use_total = (64'(in_use_total) < bytes) ? '0 : in_use_total - bytes[WORD_W-1:0];
        res.status = ST_RELEASED;
      end else begin
        cached_addr[cls][class_fill[cls]] = baddr;
        class_fill[cls]++;
        res.status = ST_CACHED;
      end
    end
    res.in_use = in_use_total;
    return res;
  endfunction

  // drive one request and record its expected result when the transfer happens
  task automatic send_request(input logic op, input logic [WORD_W-1:0] size,
                              input logic [WORD_W-1:0] baddr);
    int gap;
    gap = src_idle_on ? $urandom_range(6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {baddr, size};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pool_expected.push_back(predict_pool_outcome(op, size, baddr));
  endtask

  task automatic stop_requests();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_results_drained();
    while (pool_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // drives one register write, the caller lowers the enable afterwards
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_BLK_BYTES:   pool_cfg.blk_bytes   = value[BS_W-1:0];
      CFG_MIN_BLOCKS:  pool_cfg.min_blocks  = value[BLK_W-1:0];
      CFG_MAX_BLOCKS:  pool_cfg.max_blocks  = value[BLK_W-1:0];
      CFG_ALLOC_LIMIT: pool_cfg.alloc_limit = value;
      CFG_CACHE_LIMIT: pool_cfg.cache_limit = value;
      default: ;
    endcase
  endtask

  // reprogram all registers once the pool has gone idle
  task automatic set_pool_config(input logic [WORD_W-1:0] bs, input logic [WORD_W-1:0] minb,
      input logic [WORD_W-1:0] maxb, input logic [WORD_W-1:0] alloc,
      input logic [WORD_W-1:0] cache);
    stop_requests();
    wait_results_drained();
    write_reg(CFG_BLK_BYTES, bs);
    write_reg(CFG_MIN_BLOCKS, minb);
    write_reg(CFG_MAX_BLOCKS, maxb);
    write_reg(CFG_ALLOC_LIMIT, alloc);
    write_reg(CFG_CACHE_LIMIT, cache);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // sizes mostly land one block around the valid class band, with edge offsets
  task automatic send_random_request(input int free_pct);
    logic              op;
    logic [WORD_W-1:0] size;
    logic [WORD_W-1:0] baddr;
    logic [63:0]       span;
    int unsigned       bs;
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       blk;
    int unsigned       offs;
    op = ($urandom_range(99) < free_pct) ? OP_FREE : OP_GET;
    bs = 32'(pool_cfg.blk_bytes);
    case ($urandom_range(9))
      0: size = $urandom();
      1: size = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
      default: begin
        lo = (pool_cfg.min_blocks > 0) ? pool_cfg.min_blocks - 1 : 0;
        hi = pool_cfg.max_blocks + 1;
        blk = $urandom_range(hi, lo);
        if (blk == 0 || bs == 0) begin
          size = $urandom_range(3);
        end else begin
          case ($urandom_range(2))
            0: offs = 1;
            1: offs = bs;
            default: offs = $urandom_range(bs, 1);
          endcase
          span = 64'(blk - 1) * 64'(bs) + 64'(offs);
          size = (span > 64'hFFFF_FFFF) ? '1 : span[WORD_W-1:0];
        end
      end
    endcase
    case ($urandom_range(7))
      0: baddr = '0;
      1: baddr = '1;
      default: baddr = $urandom();
    endcase
    send_request(op, size, baddr);
  endtask

  task automatic run_random_phase(input int count, input int free_pct,
                                  input bit src_idle, input bit sink_idle);
    src_idle_on = src_idle;
    sink_idle_on = sink_idle;
    repeat (count) send_random_request(free_pct);
  endtask

  // defaults after reset: size rounding edges and lifo reuse order
  task automatic test_reset_defaults();
    send_request(OP_GET, 32'd0, 32'd0);
    send_request(OP_GET, 32'hFFFF_FFFF, 32'd0);
    send_request(OP_GET, 32'd1, 32'd0);
    send_request(OP_GET, 32'd81920, 32'd0);
    send_request(OP_GET, 32'd81921, 32'd0);
    send_request(OP_FREE, 32'd16384, 32'hFFFF_FFFF);
    send_request(OP_FREE, 32'd1, 32'h0000_0000);
    send_request(OP_GET, 32'd16384, 32'hFFFF_FFFF);
    send_request(OP_GET, 32'd2, 32'd0);
  endtask

  // a ninth free into one class finds the stack full and releases
  task automatic test_stack_full_release();
    set_pool_config(32'd64, 32'd1, 32'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < STACK_DEPTH + 1; i++)
      send_request(OP_FREE, 32'd512, 32'h1000_0000 + i);
    send_request(OP_GET, 32'd449, 32'd0);
    send_request(OP_GET, 32'd512, 32'd0);
  endtask

  // limits exactly at and just above the in-use count
  task automatic test_limit_edges();
    set_pool_config(32'd16, 32'd1, 32'd8, in_use_total, in_use_total);
    send_request(OP_GET, 32'd16, 32'd0);
    send_request(OP_FREE, 32'd16, 32'hA5A5_A5A5);
    set_pool_config(32'd16, 32'd1, 32'd8, in_use_total + 1, in_use_total + 1);
    send_request(OP_FREE, 32'd16, 32'h5A5A_5A5A);
    send_request(OP_GET, 32'd16, 32'd0);
    send_request(OP_GET, 32'd16, 32'd0);
  endtask

  // zero block size, min above max, wide grants, class index overflow, zero blocks
  task automatic test_odd_config();
    set_pool_config(32'd0, 32'd1, 32'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);
    @(negedge clk);
    cfg_we <= 1'b0;
    send_request(OP_GET, 32'd16, 32'd0);
    send_request(OP_FREE, 32'd0, 32'd0);
    set_pool_config(32'd16, 32'd8, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_GET, 32'd128, 32'd0);
    // release of more bytes than are in use clamps at zero
    set_pool_config(32'h1F_FFFF, 32'd8, 32'd15, 32'hFFFF_FFFF, 32'd0);
    send_request(OP_FREE, 32'd8 * 32'h1F_FFFF, 32'd0);
    send_request(OP_GET, 32'd15 * 32'h1F_FFFF, 32'd0);
    send_request(OP_GET, 32'd9 * 32'h1F_FFFF - 32'd5, 32'd0);
    set_pool_config(32'h1F_FFFF, 32'd1, 32'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_GET, 32'd9 * 32'h1F_FFFF, 32'd0);
    set_pool_config(32'd16, 32'd0, 32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_FREE, 32'd0, 32'hFFFF_FFFF);
    send_request(OP_GET, 32'd0, 32'd0);
  endtask

  // long result stall fills the block; then a pause until everything has come back
  task automatic test_backpressure();
    set_pool_config(32'd16384, 32'd1, 32'd5, 32'd4194304, 32'd2097152);
    src_idle_on = 1'b0;
    sink_hold_cycles = BACKLOG_HOLD;
    repeat (12) send_random_request(50);
    stop_requests();
    wait_results_drained();
    repeat (6) send_random_request(50);
  endtask

  task automatic test_random_phases();
    logic [WORD_W-1:0] bs;
    logic [WORD_W-1:0] minb;
    logic [WORD_W-1:0] maxb;
    logic [WORD_W-1:0] lim [2];
    set_pool_config(32'd16384, 32'd1, 32'd5, 32'd4194304, 32'd2097152);
    run_random_phase(200, 50, 1'b1, 1'b1);
    set_pool_config(32'd1, 32'd1, 32'd8, 32'd20, 32'd10);
    run_random_phase(200, 60, 1'b1, 1'b0);
    set_pool_config(32'h10_0000, 32'd1, 32'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random_phase(200, 55, 1'b0, 1'b0);
    set_pool_config(32'd4096, 32'd8, 32'd8, 32'd65536, 32'd32768);
    run_random_phase(150, 50, 1'b0, 1'b1);
    // random register sets, limits from the edges and from the working range
    repeat (4) begin
      bs = $urandom_range(1, 32'h10_0000);
      minb = $urandom_range(8, 1);
      maxb = $urandom_range(8, 1);
      if ($urandom_range(3) != 0 && minb > maxb) begin
        minb = minb ^ maxb;
        maxb = minb ^ maxb;
        minb = minb ^ maxb;
      end
      for (int i = 0; i < 2; i++) begin
        case ($urandom_range(3))
          0: lim[i] = '0;
          1: lim[i] = '1;
          2: lim[i] = $urandom();
          default: lim[i] = $urandom_range(bs * 32);
        endcase
      end
      set_pool_config(bs, minb, maxb, lim[0], lim[1]);
      run_random_phase(80, $urandom_range(70, 30), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
    end
  endtask

  // largest grants until the in-use count pins at all ones, then mixed traffic
  task automatic test_grant_saturation();
    set_pool_config(32'h1F_FFFF, 32'd8, 32'd15, 32'hFFFF_FFFF, 32'd0);
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    while (in_use_total != '1)
      send_request(OP_GET, 32'd15 * 32'h1F_FFFF, $urandom());
    send_request(OP_GET, 32'd8 * 32'h1F_FFFF, 32'd0);
    run_random_phase(100, 50, 1'b1, 1'b1);
  endtask

  // result side: random stall per result, or one long hold when asked for
  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      if (sink_hold_cycles > 0) begin
        @(negedge clk);
        m_axis_tready <= 1'b0;
        repeat (sink_hold_cycles) @(negedge clk);
        sink_hold_cycles = 0;
      end else begin
        stall = sink_idle_on ? $urandom_range(6) : 0;
        if (stall > 0) begin
          @(negedge clk);
          m_axis_tready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
      end
      @(negedge clk);
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // compare each result transfer with the oldest pending expectation
  always @(posedge clk) begin : result_check
    pool_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pool_expected.size() == 0) begin
        report_mismatch("unexpected result status", 32'(m_axis_tuser), 32'd0);
      end else begin
        want = pool_expected.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
        if (m_axis_tdata[31:0] !== want.addr)
          report_mismatch("addr", m_axis_tdata[31:0], want.addr);
        if (m_axis_tdata[55:32] !== want.granted)
          report_mismatch("granted_bytes", 32'(m_axis_tdata[55:32]), 32'(want.granted));
        if (m_axis_tdata[87:56] !== want.in_use)
          report_mismatch("in_use_bytes", m_axis_tdata[87:56], want.in_use);
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    reset_pool_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_stack_full_release();
    test_limit_edges();
    test_odd_config();
    test_backpressure();
    test_random_phases();
    test_grant_saturation();

    // drain and let the pipeline settle before the verdict
    stop_requests();
    wait_results_drained();
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
